/* src/three_axis_pid_attitude_controller_top_defines.svh */
// ----------------------------------------------------------------------------
// three_axis_pid_attitude_controller_top_defines
// assertion macros shared by the attitude controller rtl
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_PID_ATTITUDE_CONTROLLER_TOP_DEFINES_SVH
`define THREE_AXIS_PID_ATTITUDE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TAPC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TAPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tapc_pkg.sv */
// ----------------------------------------------------------------------------
// tapc_pkg
// shared types, constants and helpers of the attitude controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tapc_pkg;

    localparam int ANGLE_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int RND_SH      = 8;
    localparam int PID_MAX_DEF = 25600;
    localparam int REG_IDX_W   = 3;

    // half and full turn in q10.6 degrees
    localparam logic signed [ANGLE_W:0] HALF_TURN = 17'sd11520;
    localparam logic signed [ANGLE_W:0] FULL_TURN = 17'sd23040;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROLL_KP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROLL_KI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROLL_KD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_KP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_KI = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_KD = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_YAW_KP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_YAW_KD   = 3'd7;

    // request kind
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [GAIN_W-1:0]         gain_t;

    // pipeline strobes from the control unit to the lanes
    typedef struct packed {
        logic accept;   // word taken into stage 1
        logic clr0;     // word being taken is a clear request
        logic adv1;     // stage 1 moves to stage 2
        logic adv2;     // stage 2 moves to the output register
        logic clr2;     // word in stage 2 is a clear request
    } pipe_ctl_t;

    // saturate a one-bit-wider value to the angle range
    function automatic angle_t sat_angle(input logic signed [ANGLE_W:0] v);
        angle_t r;
        if (v[ANGLE_W] != v[ANGLE_W-1]) begin
            r = v[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

    // a minus b, saturated
    function automatic angle_t angle_diff(input angle_t a, input angle_t b);
        logic signed [ANGLE_W:0] d;
        d = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
        return sat_angle(d);
    endfunction

endpackage

/* src/tapc_err.sv */
// ----------------------------------------------------------------------------
// tapc_err
// yaw error: plain saturated difference or wrapped compass distance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tapc_err (
    input  tapc_pkg::angle_t meas,
    input  tapc_pkg::angle_t targ,
    input  logic             compass,
    output tapc_pkg::angle_t err
);

    localparam int EW = tapc_pkg::ANGLE_W + 1;

    logic signed [EW-1:0] meas_sh;
    logic signed [EW-1:0] targ_sh;
    logic signed [EW-1:0] meas_red;
    logic signed [EW-1:0] targ_red;
    logic signed [EW-1:0] e_raw;
    logic signed [EW-1:0] mag;
    logic signed [EW-1:0] other;
    logic signed [EW-1:0] m_min;
    logic signed [EW-1:0] folded;

    // shift by half a turn, then truncated mod of a full turn
    // (the shifted value never reaches minus a full turn)
    assign meas_sh  = {meas[EW-2], meas} + tapc_pkg::HALF_TURN;
    assign targ_sh  = {targ[EW-2], targ} + tapc_pkg::HALF_TURN;
    assign meas_red = (meas_sh >= tapc_pkg::FULL_TURN) ? meas_sh - tapc_pkg::FULL_TURN : meas_sh;
    assign targ_red = (targ_sh >= tapc_pkg::FULL_TURN) ? targ_sh - tapc_pkg::FULL_TURN : targ_sh;

    // fold to the shorter way round, signed like measured minus target
    assign e_raw  = meas_red - targ_red;
    assign mag    = e_raw[EW-1] ? -e_raw : e_raw;
    assign other  = tapc_pkg::FULL_TURN - mag;
    assign m_min  = (mag < other) ? mag : other;
    assign folded = e_raw[EW-1] ? -m_min : m_min;

    assign err = compass ? tapc_pkg::sat_angle(folded) : tapc_pkg::angle_diff(targ, meas);

endmodule

/* src/tapc_lane.sv */
// ----------------------------------------------------------------------------
// tapc_lane
// one axis of the pid datapath: error capture, gain products, sum and clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_axis_pid_attitude_controller_top_defines.svh"

module tapc_lane #(
    parameter int PID_MAX = tapc_pkg::PID_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tapc_pkg::pipe_ctl_t ctl,
    input  tapc_pkg::angle_t    err,
    input  tapc_pkg::gain_t     kp,
    input  tapc_pkg::gain_t     ki,
    input  tapc_pkg::gain_t     kd,
    output tapc_pkg::angle_t    drive
);

    localparam int AW    = tapc_pkg::ANGLE_W;
    localparam int GW    = tapc_pkg::GAIN_W;
    localparam int SH    = tapc_pkg::RND_SH;
    localparam int P_W   = GW + AW + 1;
    localparam int D_W   = GW + AW + 2;
    localparam int PR_W  = P_W - SH;
    localparam int DR_W  = D_W - SH;
    localparam int SUM_W = DR_W + 1;

    localparam logic signed [P_W-1:0]   P_HALF = P_W'(2 ** (SH - 1));
    localparam logic signed [D_W-1:0]   D_HALF = D_W'(2 ** (SH - 1));
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(PID_MAX);
    localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;
    localparam tapc_pkg::angle_t        LIM_A  = AW'(PID_MAX);

    tapc_pkg::angle_t last_err_reg;
    tapc_pkg::angle_t err1_reg;
    tapc_pkg::angle_t prev1_reg;
    tapc_pkg::angle_t integ_reg;
    tapc_pkg::angle_t integ_next;

    logic signed [P_W-1:0] pterm2_reg;
    logic signed [P_W-1:0] iterm2_reg;
    logic signed [D_W-1:0] dterm2_reg;

    logic signed [GW:0]    kp_s;
    logic signed [GW:0]    ki_s;
    logic signed [GW:0]    kd_s;
    logic signed [AW:0]    diff1;
    logic signed [P_W-1:0] pprod;
    logic signed [P_W-1:0] iprod;
    logic signed [D_W-1:0] dprod;

    logic signed [PR_W-1:0]  p_r;
    logic signed [PR_W-1:0]  i_r;
    logic signed [DR_W-1:0]  d_r;
    logic signed [SUM_W-1:0] dsum;
    logic signed [SUM_W-1:0] isum;

    function automatic tapc_pkg::angle_t clamp_lim(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > LIM_HI) begin
            c = LIM_HI;
        end else if (v < LIM_LO) begin
            c = LIM_LO;
        end else begin
            c = v;
        end
        return c[AW-1:0];
    endfunction

    // stage 1: error and the previous error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (ctl.accept) begin
            last_err_reg <= ctl.clr0 ? '0 : err;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            err1_reg  <= err;
            prev1_reg <= last_err_reg;
        end
    end

    // stage 2: gain products with the rounding half added
    assign kp_s  = {1'b0, kp};
    assign ki_s  = {1'b0, ki};
    assign kd_s  = {1'b0, kd};
    assign diff1 = {err1_reg[AW-1], err1_reg} - {prev1_reg[AW-1], prev1_reg};
    assign pprod = P_W'(kp_s) * P_W'(err1_reg);
    assign iprod = P_W'(ki_s) * P_W'(err1_reg);
    assign dprod = D_W'(kd_s) * D_W'(diff1);

    always_ff @(posedge aclk) begin
        if (ctl.adv1) begin
            pterm2_reg <= pprod + P_HALF;
            iterm2_reg <= iprod + P_HALF;
            dterm2_reg <= dprod + D_HALF;
        end
    end

    // stage 3: rescale, sum, clamp; integral update
    assign p_r  = pterm2_reg[P_W-1:SH];
    assign i_r  = iterm2_reg[P_W-1:SH];
    assign d_r  = dterm2_reg[D_W-1:SH];
    assign dsum = SUM_W'(p_r) + SUM_W'(d_r) + SUM_W'(integ_reg);
    assign isum = SUM_W'(integ_reg) + SUM_W'(i_r);

    assign drive      = ctl.clr2 ? '0 : clamp_lim(dsum);
    assign integ_next = ctl.clr2 ? '0 : clamp_lim(isum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctl.adv2) begin
            integ_reg <= integ_next;
        end
    end

    `TAPC_ASSERT_NEXT(a_integ_cleared, aclk, aresetn, ctl.adv2 && ctl.clr2, integ_reg == '0, "integral not zero after clear")
    `TAPC_ASSERT_IMPL(a_integ_bounded, aclk, aresetn, 1'b1, (integ_reg <= LIM_A) && (integ_reg >= -LIM_A), "integral out of range")

endmodule

/* src/tapc_ctrl.sv */
// ----------------------------------------------------------------------------
// tapc_ctrl
// stage valid bits and handshake for the three-stage lane pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_axis_pid_attitude_controller_top_defines.svh"

module tapc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                req_type,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tapc_pkg::pipe_ctl_t ctl
);

    logic valid1_reg;
    logic valid1_next;
    logic valid2_reg;
    logic valid2_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic clr1_reg;
    logic clr2_reg;

    logic ready_out;
    logic ready1;
    logic ready2;
    logic accept;
    logic adv1;
    logic adv2;

    // a stage may take a word when empty or when it is itself moving on
    assign ready_out = !out_valid_reg || m_ready;
    assign adv2      = valid2_reg && ready_out;
    assign ready2    = !valid2_reg || ready_out;
    assign adv1      = valid1_reg && ready2;
    assign ready1    = !valid1_reg || ready2;
    assign accept    = s_valid && ready1;

    assign valid1_next    = accept || (valid1_reg && !adv1);
    assign valid2_next    = adv1 || (valid2_reg && !adv2);
    assign out_valid_next = adv2 || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            valid1_reg    <= valid1_next;
            valid2_reg    <= valid2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            clr1_reg <= (req_type == tapc_pkg::REQ_CLEAR);
        end
        if (adv1) begin
            clr2_reg <= clr1_reg;
        end
    end

    assign s_ready    = ready1;
    assign m_valid    = out_valid_reg;
    assign ctl.accept = accept;
    assign ctl.clr0   = (req_type == tapc_pkg::REQ_CLEAR);
    assign ctl.adv1   = adv1;
    assign ctl.adv2   = adv2;
    assign ctl.clr2   = clr2_reg;

    `TAPC_ASSERT_IMPL(a_stall_only_full, aclk, aresetn, !s_ready, valid1_reg && valid2_reg && out_valid_reg, "input stalled with a free stage")
    `TAPC_ASSERT_NEXT(a_adv1_fills, aclk, aresetn, adv1, valid2_reg, "stage 2 empty after advance")

endmodule

/* src/three_axis_pid_attitude_controller_top.sv */
// ----------------------------------------------------------------------------
// three_axis_pid_attitude_controller_top
// roll / pitch / yaw pid attitude controller, one drive triple per tick word
// ----------------------------------------------------------------------------
// Takes one tick word per clock when not stalled by m_axis_tready and presents
// one word of three drive values for it (error capture when the word is taken,
// gain multiply into stage 2, then sum and clamp with integral update into the
// output register); sustained rate is one word per cycle without back-pressure,
// set by the three-stage lane pipeline in which every state loop (last error,
// integral) closes within a single stage. Each axis runs in its own lane;
// yaw has no integral and may use the wrapped compass error. A clear
// request zeroes integrals and last errors and returns all-zero drives.
// Gains are unsigned q8.8, written by the user through the plain cfg port while
// idle; the block does not enforce this. s_axis_tready depends combinationally
// on m_axis_tready through the stage ready chain; the output word is held in a register.
`timescale 1ns / 1ps
`include "three_axis_pid_attitude_controller_top_defines.svh"

module three_axis_pid_attitude_controller_top #(
    parameter int PID_MAX = tapc_pkg::PID_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // tick words in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // roll_measured, roll_target, pitch_measured, pitch_target,
    // yaw_measured, yaw_target (16 bits each, lowest first)
    input  logic [95:0]                      s_axis_tdata,
    // req_type, compass_mode
    input  logic [1:0]                       s_axis_tuser,

    // drive words out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // roll_drive, pitch_drive, yaw_drive (16 bits each, lowest first)
    output logic [47:0]                      m_axis_tdata,

    // gain register writes
    input  logic                             cfg_wr_en,
    input  logic [tapc_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [tapc_pkg::GAIN_W-1:0]      cfg_data
);

    localparam int AW = tapc_pkg::ANGLE_W;
    localparam tapc_pkg::angle_t LIM_A = AW'(PID_MAX);

    // gain registers
    tapc_pkg::gain_t roll_kp_reg;
    tapc_pkg::gain_t roll_ki_reg;
    tapc_pkg::gain_t roll_kd_reg;
    tapc_pkg::gain_t pitch_kp_reg;
    tapc_pkg::gain_t pitch_ki_reg;
    tapc_pkg::gain_t pitch_kd_reg;
    tapc_pkg::gain_t yaw_kp_reg;
    tapc_pkg::gain_t yaw_kd_reg;

    // input word fields
    logic             req_type;
    logic             compass_mode;
    tapc_pkg::angle_t roll_measured;
    tapc_pkg::angle_t roll_target;
    tapc_pkg::angle_t pitch_measured;
    tapc_pkg::angle_t pitch_target;
    tapc_pkg::angle_t yaw_measured;
    tapc_pkg::angle_t yaw_target;

    // per-axis errors and drives
    tapc_pkg::angle_t roll_err;
    tapc_pkg::angle_t pitch_err;
    tapc_pkg::angle_t yaw_err;
    tapc_pkg::angle_t roll_drive;
    tapc_pkg::angle_t pitch_drive;
    tapc_pkg::angle_t yaw_drive;

    tapc_pkg::pipe_ctl_t ctl;

    // merged output register
    tapc_pkg::angle_t roll_drive_reg;
    tapc_pkg::angle_t pitch_drive_reg;
    tapc_pkg::angle_t yaw_drive_reg;

    // config writes; indexes past the list do not exist with this index width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_kp_reg  <= '0;
            roll_ki_reg  <= '0;
            roll_kd_reg  <= '0;
            pitch_kp_reg <= '0;
            pitch_ki_reg <= '0;
            pitch_kd_reg <= '0;
            yaw_kp_reg   <= '0;
            yaw_kd_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tapc_pkg::REG_ROLL_KP:  roll_kp_reg  <= cfg_data;
                tapc_pkg::REG_ROLL_KI:  roll_ki_reg  <= cfg_data;
                tapc_pkg::REG_ROLL_KD:  roll_kd_reg  <= cfg_data;
                tapc_pkg::REG_PITCH_KP: pitch_kp_reg <= cfg_data;
                tapc_pkg::REG_PITCH_KI: pitch_ki_reg <= cfg_data;
                tapc_pkg::REG_PITCH_KD: pitch_kd_reg <= cfg_data;
                tapc_pkg::REG_YAW_KP:   yaw_kp_reg   <= cfg_data;
                tapc_pkg::REG_YAW_KD:   yaw_kd_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack the input word
    assign req_type       = s_axis_tuser[0];
    assign compass_mode   = s_axis_tuser[1];
    assign roll_measured  = s_axis_tdata[15:0];
    assign roll_target    = s_axis_tdata[31:16];
    assign pitch_measured = s_axis_tdata[47:32];
    assign pitch_target   = s_axis_tdata[63:48];
    assign yaw_measured   = s_axis_tdata[79:64];
    assign yaw_target     = s_axis_tdata[95:80];

    // errors: target minus measured; compass-wrapped yaw is measured minus target
    assign roll_err  = tapc_pkg::angle_diff(roll_target, roll_measured);
    assign pitch_err = tapc_pkg::angle_diff(pitch_target, pitch_measured);

    tapc_err u_yaw_err (
        .meas    (yaw_measured),
        .targ    (yaw_target),
        .compass (compass_mode),
        .err     (yaw_err)
    );

    // pipeline control shared by all lanes
    tapc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .req_type (req_type),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .ctl      (ctl)
    );

    // roll and pitch lanes carry an integral
    tapc_lane #(.PID_MAX(PID_MAX)) u_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .err     (roll_err),
        .kp      (roll_kp_reg),
        .ki      (roll_ki_reg),
        .kd      (roll_kd_reg),
        .drive   (roll_drive)
    );

    tapc_lane #(.PID_MAX(PID_MAX)) u_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .err     (pitch_err),
        .kp      (pitch_kp_reg),
        .ki      (pitch_ki_reg),
        .kd      (pitch_kd_reg),
        .drive   (pitch_drive)
    );

    // yaw is pd only: zero integral gain keeps its integral at zero
    tapc_lane #(.PID_MAX(PID_MAX)) u_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .err     (yaw_err),
        .kp      (yaw_kp_reg),
        .ki      ('0),
        .kd      (yaw_kd_reg),
        .drive   (yaw_drive)
    );

    // merge the three lanes into the output word
    always_ff @(posedge aclk) begin
        if (ctl.adv2) begin
            roll_drive_reg  <= roll_drive;
            pitch_drive_reg <= pitch_drive;
            yaw_drive_reg   <= yaw_drive;
        end
    end

    assign m_axis_tdata = {yaw_drive_reg, pitch_drive_reg, roll_drive_reg};

    `TAPC_ASSERT_IMPL(a_roll_bounded, aclk, aresetn, m_axis_tvalid, (roll_drive_reg <= LIM_A) && (roll_drive_reg >= -LIM_A), "roll drive out of range")
    `TAPC_ASSERT_IMPL(a_yaw_bounded, aclk, aresetn, m_axis_tvalid, (yaw_drive_reg <= LIM_A) && (yaw_drive_reg >= -LIM_A), "yaw drive out of range")
    `TAPC_ASSERT_NEXT(a_clear_zero, aclk, aresetn, ctl.adv2 && ctl.clr2, m_axis_tdata == '0, "clear word with nonzero drive")

endmodule
